>>> sv/gprg_pkg.sv
// ----------------------------------------------------------------------------
// gprg_pkg
// shared constants for the gop picture role generator
// ----------------------------------------------------------------------------
package gprg_pkg;

  // default picture number width
  localparam int PICNUM_BITS_DEF = 32;

  // number of divisions run side by side in each cell
  localparam int NUM_DIV = 4;
  localparam int DIV_A   = 0;  // x / gop_length
  localparam int DIV_B   = 1;  // x / l1_spacing
  localparam int DIV_C   = 2;  // picture number / l1_spacing
  localparam int DIV_D   = 3;  // (p - l1_spacing) / gop_length

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GOP_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_L1_SPACING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTERLACED = 2'd2;

  // picture kinds
  localparam logic [1:0] KIND_INTRA_REF    = 2'd0;
  localparam logic [1:0] KIND_INTRA_NONREF = 2'd1;
  localparam logic [1:0] KIND_INTER_REF    = 2'd2;
  localparam logic [1:0] KIND_INTER_NONREF = 2'd3;

  // expiry values
  localparam logic [30:0] NEVER_EXPIRES    = 31'h4000_0000;
  localparam logic [30:0] PROG_MID_EXPIRY  = 31'd22;
  localparam logic [30:0] FIELD_MID_EXPIRY = 31'd4;

endpackage

>>> sv/gop_picture_role_generator.sv
// ----------------------------------------------------------------------------
// gop_picture_role_generator
// coding role of a picture or field from its display-order number
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one picture (or field) number per word; m_axis returns
//   one role word per input: kind, expiry, reference count, two reference
//   numbers and a configuration error flag
//   the cfg channel writes gop_length (index 0), l1_spacing (index 1) and
//   interlaced (index 2); it is always ready; the user must write it only
//   while the block is idle, not enforced; other indexes are dropped
//   a row of PICNUM_BITS division cells works out one quotient bit per
//   cell for four divisions at once (by gop length and l1 spacing), so a
//   result word is valid on m_axis once its input word has passed the
//   register of every cell and then the output register, which the last
//   cell feeds
//   throughput is one word per cycle unless stalled; the whole row advances together
//   after reset the row is empty, registers hold gop_length 0,
//   l1_spacing 1, progressive mode
//   when the receiver stalls with a word in the output register the row
//   freezes and s_axis_tready drops until that word is taken
// ----------------------------------------------------------------------------
module gop_picture_role_generator #(
  parameter int PICNUM_BITS = gprg_pkg::PICNUM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gprg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  // input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // picture_number
  // result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // picture_kind, expiry_time, ref_count, first_ref, second_ref,
  // config_error, zero pad
  output logic [103:0]                   m_axis_tdata
);

  localparam int W = PICNUM_BITS;
  localparam int N = gprg_pkg::NUM_DIV;

  // configuration registers
  logic [7:0] gop_q, spc_q;
  logic       ilace_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gop_q   <= 8'd0;
      spc_q   <= 8'd1;
      ilace_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        gprg_pkg::REG_GOP_LENGTH: gop_q   <= cfg_data_i;
        gprg_pkg::REG_L1_SPACING: spc_q   <= cfg_data_i;
        gprg_pkg::REG_INTERLACED: ilace_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // whole row advances unless a finished word is stuck at the output
  logic out_valid_q;
  logic en;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // cell row, position 0 is the input
  logic                   v_c    [W+1];
  logic [W-1:0]           p_c    [W+1];
  logic [W-1:0]           prev_c [W+1];
  logic [N-1:0][7:0]      rem_c  [W+1];
  logic [N-1:0][W-1:0]    quot_c [W+1];

  assign v_c[0]    = s_axis_tvalid;
  assign p_c[0]    = s_axis_tdata[W-1:0];
  // previous l1 picture, needed for its position in the gop
  assign prev_c[0] = s_axis_tdata[W-1:0] - W'(spc_q);
  assign rem_c[0]  = '0;
  assign quot_c[0] = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    gprg_cell #(.W(W), .IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_c[i]),
      .p_i     (p_c[i]),
      .prev_i  (prev_c[i]),
      .rem_i   (rem_c[i]),
      .quot_i  (quot_c[i]),
      .g_i     (gop_q),
      .s_i     (spc_q),
      .ilace_i (ilace_q),
      .valid_o (v_c[i+1]),
      .p_o     (p_c[i+1]),
      .prev_o  (prev_c[i+1]),
      .rem_o   (rem_c[i+1]),
      .quot_o  (quot_c[i+1])
    );
  end

  // role decode on the last cell's results
  logic [W-1:0] p, f, qa, qb, qc;
  logic [7:0]   ra, rb, rd, s1;
  logic         odd;
  logic [W-1:0] qa_g, qb1_s, qc_s, qc1_s, p_2s;
  logic [1:0]   kind;
  logic [30:0]  exp_t;
  logic [1:0]   nref;
  logic [W-1:0] r0, r1;
  logic         err;

  always_comb begin
    p     = p_c[W];
    f     = {1'b0, p[W-1:1]};
    odd   = p[0];
    qa    = quot_c[W][gprg_pkg::DIV_A];
    qb    = quot_c[W][gprg_pkg::DIV_B];
    qc    = quot_c[W][gprg_pkg::DIV_C];
    ra    = rem_c[W][gprg_pkg::DIV_A];
    rb    = rem_c[W][gprg_pkg::DIV_B];
    rd    = rem_c[W][gprg_pkg::DIV_D];
    s1    = spc_q - 8'd1;
    qa_g  = W'(qa * gop_q);
    qb1_s = W'((qb + W'(1)) * spc_q);
    qc_s  = W'(qc * spc_q);
    qc1_s = W'((qc + W'(1)) * spc_q);
    p_2s  = p - W'({spc_q, 1'b0});
  end

  always_comb begin
    kind  = gprg_pkg::KIND_INTRA_REF;
    exp_t = '0;
    nref  = 2'd0;
    r0    = '0;
    r1    = '0;
    err   = 1'b0;
    if (!ilace_q) begin
      if (gop_q != 8'd0) begin
        if (ra == 8'd0) begin
          kind  = (gop_q > 8'd1) ? gprg_pkg::KIND_INTRA_REF : gprg_pkg::KIND_INTRA_NONREF;
          exp_t = 31'(gop_q);
        end else if (spc_q == 8'd0) begin
          err = 1'b1;
        end else if (rb == 8'd0) begin
          kind  = gprg_pkg::KIND_INTER_REF;
          r0    = prev_c[W];
          nref  = 2'd1;
          if (rd != 8'd0) begin
            r1   = qa_g;
            nref = 2'd2;
          end
          exp_t = 31'(spc_q);
        end else if (p == '1 || rb == s1) begin
          // next picture is an l1 picture (wrap to zero counts)
          kind  = gprg_pkg::KIND_INTER_NONREF;
          r0    = p - W'(1);
          r1    = p + W'(1);
          nref  = 2'd2;
          exp_t = 31'd1;
        end else begin
          kind  = gprg_pkg::KIND_INTER_REF;
          r0    = p - W'(1);
          r1    = qb1_s;
          nref  = 2'd2;
          exp_t = gprg_pkg::PROG_MID_EXPIRY;
        end
      end else begin
        if (p == '0) begin
          exp_t = gprg_pkg::NEVER_EXPIRES;
        end else if (spc_q == 8'd0) begin
          err = 1'b1;
        end else if (rb == 8'd0) begin
          kind  = gprg_pkg::KIND_INTER_REF;
          nref  = 2'd1;
          if (p != W'(spc_q)) begin
            r1   = p - W'(spc_q);
            nref = 2'd2;
          end
          exp_t = 31'(spc_q);
        end else begin
          kind  = gprg_pkg::KIND_INTER_NONREF;
          r0    = qb * W'(spc_q);
          r1    = qb1_s;
          nref  = 2'd2;
          exp_t = 31'd1;
        end
      end
    end else begin
      if (gop_q != 8'd0) begin
        if (ra == 8'd0) begin
          if (gop_q > 8'd1) begin
            kind  = gprg_pkg::KIND_INTRA_REF;
            exp_t = 31'({gop_q, 1'b0});
            if (odd) begin
              kind = gprg_pkg::KIND_INTER_REF;
              r0   = p - W'(1);
              nref = 2'd1;
            end
          end else begin
            kind  = gprg_pkg::KIND_INTRA_NONREF;
            exp_t = 31'(gop_q);
          end
        end else if (spc_q == 8'd0) begin
          err = 1'b1;
        end else if (rb == 8'd0) begin
          kind = gprg_pkg::KIND_INTER_REF;
          nref = 2'd2;
          if (odd) begin
            r0 = p - W'(1);
            r1 = p_2s;
          end else begin
            r0 = p_2s;
            r1 = p_2s + W'(1);
          end
          exp_t = 31'({spc_q, 1'b1});
        end else if (rb == s1) begin
          kind  = gprg_pkg::KIND_INTER_NONREF;
          r0    = p - W'(2);
          r1    = p + W'(2);
          nref  = 2'd2;
          exp_t = 31'd1;
        end else begin
          kind  = gprg_pkg::KIND_INTER_REF;
          r0    = p - W'(2);
          r1    = {qb1_s[W-2:0], odd};
          nref  = 2'd2;
          exp_t = gprg_pkg::FIELD_MID_EXPIRY;
        end
      end else begin
        if (f == '0) begin
          exp_t = gprg_pkg::NEVER_EXPIRES;
        end else if (spc_q == 8'd0) begin
          err = 1'b1;
        end else if (rb == 8'd0) begin
          kind = gprg_pkg::KIND_INTER_REF;
          nref = 2'd1;
          if (f != W'(spc_q)) begin
            r1   = p_2s;
            nref = 2'd2;
          end
          exp_t = 31'({spc_q, 1'b0});
        end else begin
          // references from the picture number itself
          kind  = gprg_pkg::KIND_INTER_NONREF;
          r0    = qc_s;
          r1    = qc1_s;
          nref  = 2'd2;
          exp_t = 31'd1;
        end
      end
    end
    if (err) begin
      kind  = gprg_pkg::KIND_INTRA_REF;
      exp_t = '0;
      nref  = 2'd0;
      r0    = '0;
      r1    = '0;
    end
  end

  // output register
  logic [103:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_c[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {4'd0, err, 32'(r1), 32'(r0), nref, exp_t, kind};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> sv/gprg_cell.sv
// ----------------------------------------------------------------------------
// gprg_cell
// one restoring division step for each of the parallel dividers
// ----------------------------------------------------------------------------
module gprg_cell #(
  parameter int W   = gprg_pkg::PICNUM_BITS_DEF,
  parameter int IDX = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [W-1:0]                          p_i,
  input  logic [W-1:0]                          prev_i,
  input  logic [gprg_pkg::NUM_DIV-1:0][7:0]     rem_i,
  input  logic [gprg_pkg::NUM_DIV-1:0][W-1:0]   quot_i,
  input  logic [7:0]                            g_i,
  input  logic [7:0]                            s_i,
  input  logic                                  ilace_i,
  output logic                                  valid_o,
  output logic [W-1:0]                          p_o,
  output logic [W-1:0]                          prev_o,
  output logic [gprg_pkg::NUM_DIV-1:0][7:0]     rem_o,
  output logic [gprg_pkg::NUM_DIV-1:0][W-1:0]   quot_o
);

  localparam int B = W - 1 - IDX;

  logic [W-1:0]                          x;
  logic [gprg_pkg::NUM_DIV-1:0]          dbit;
  logic [gprg_pkg::NUM_DIV-1:0][7:0]     dvs;
  logic [gprg_pkg::NUM_DIV-1:0][7:0]     rem_d;
  logic [gprg_pkg::NUM_DIV-1:0][W-1:0]   quot_d;
  logic                                  valid_q;
  logic [W-1:0]                          p_q;
  logic [W-1:0]                          prev_q;
  logic [gprg_pkg::NUM_DIV-1:0][7:0]     rem_q;
  logic [gprg_pkg::NUM_DIV-1:0][W-1:0]   quot_q;

  // field number in interlaced mode
  assign x = ilace_i ? {1'b0, p_i[W-1:1]} : p_i;

  always_comb begin
    dbit[gprg_pkg::DIV_A] = x[B];
    dbit[gprg_pkg::DIV_B] = x[B];
    dbit[gprg_pkg::DIV_C] = p_i[B];
    dbit[gprg_pkg::DIV_D] = prev_i[B];
    dvs[gprg_pkg::DIV_A]  = g_i;
    dvs[gprg_pkg::DIV_B]  = s_i;
    dvs[gprg_pkg::DIV_C]  = s_i;
    dvs[gprg_pkg::DIV_D]  = g_i;
  end

  always_comb begin
    logic [8:0] t;
    for (int k = 0; k < gprg_pkg::NUM_DIV; k++) begin
      t = {rem_i[k], dbit[k]};
      if (t >= {1'b0, dvs[k]}) begin
        rem_d[k]  = 8'(t - {1'b0, dvs[k]});
        quot_d[k] = {quot_i[k][W-2:0], 1'b1};
      end else begin
        rem_d[k]  = t[7:0];
        quot_d[k] = {quot_i[k][W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_i;
      prev_q <= prev_i;
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign valid_o = valid_q;
  assign p_o     = p_q;
  assign prev_o  = prev_q;
  assign rem_o   = rem_q;
  assign quot_o  = quot_q;

endmodule

>>> dv/gop_picture_role_generator_tb.sv
// ----------------------------------------------------------------------------
// gop_picture_role_generator_tb
// checks picture roles against an in-bench predictor over several gop setups
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gop_picture_role_generator_tb;

  localparam int LATENCY = 40;

  // first member sits in the top bits, so the order is reversed
  typedef struct packed {
    logic        err;
    logic [31:0] ref1;
    logic [31:0] ref0;
    logic [1:0]  nref;
    logic [30:0] expiry;
    logic [1:0]  kind;
  } role_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [gprg_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // picture_number
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // picture_kind, expiry_time, ref_count, first_ref, second_ref, config_error
  logic [103:0] m_axis_tdata;

  // predictor copy of the registers
  logic [7:0] gop_len_q = 8'd0;
  logic [7:0] l1_sp_q = 8'd1;
  logic       field_mode_q = 1'b0;

  role_t expected_roles[$];
  int errors = 0;
  int unsigned rx_wait = 0;

  always #2 clk_i = ~clk_i;

  gop_picture_role_generator u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // role of one number, all picture arithmetic modulo 2^32
  function automatic role_t predict_role(logic [31:0] p);
    role_t o;
    logic [31:0] g, s, f, r0, r1;
    logic [1:0] n;
    logic odd;
    o = '0; n = 2'd0; r0 = '0; r1 = '0;
    g = 32'(gop_len_q); s = 32'(l1_sp_q);
    f = p >> 1; odd = p[0];
    if (!field_mode_q) begin
      if (g > 0) begin
        if (p % g == 0) begin
          o.kind = (g > 1) ? gprg_pkg::KIND_INTRA_REF : gprg_pkg::KIND_INTRA_NONREF;
          o.expiry = 31'(g);
        end else if (s == 0) begin
          o.err = 1'b1;
        end else if (p % s == 0) begin
          o.kind = gprg_pkg::KIND_INTER_REF;
          r0 = p - s; n = 2'd1;
          if (r0 % g > 0) begin r1 = (p / g) * g; n = 2'd2; end
          o.expiry = 31'(s);
        end else if ((p + 32'd1) % s == 0) begin
          o.kind = gprg_pkg::KIND_INTER_NONREF;
          r0 = p - 32'd1; r1 = p + 32'd1; n = 2'd2; o.expiry = 31'd1;
        end else begin
          o.kind = gprg_pkg::KIND_INTER_REF;
          r0 = p - 32'd1; r1 = (p / s + 32'd1) * s; n = 2'd2;
          o.expiry = gprg_pkg::PROG_MID_EXPIRY;
        end
      end else begin
        if (p == 0) begin
          o.kind = gprg_pkg::KIND_INTRA_REF; o.expiry = gprg_pkg::NEVER_EXPIRES;
        end else if (s == 0) begin
          o.err = 1'b1;
        end else if (p % s == 0) begin
          o.kind = gprg_pkg::KIND_INTER_REF; r0 = '0; n = 2'd1;
          if (p != s) begin r1 = p - s; n = 2'd2; end
          o.expiry = 31'(s);
        end else begin
          o.kind = gprg_pkg::KIND_INTER_NONREF;
          r0 = (p / s) * s; r1 = (p / s + 32'd1) * s; n = 2'd2;
          o.expiry = 31'd1;
        end
      end
    end else begin
      if (g > 0) begin
        if (f % g == 0) begin
          if (g > 1) begin
            o.kind = gprg_pkg::KIND_INTRA_REF; o.expiry = 31'(g * 32'd2);
            if (odd) begin
              o.kind = gprg_pkg::KIND_INTER_REF; r0 = p - 32'd1; n = 2'd1;
            end
          end else begin
            o.kind = gprg_pkg::KIND_INTRA_NONREF; o.expiry = 31'(g);
          end
        end else if (s == 0) begin
          o.err = 1'b1;
        end else if (f % s == 0) begin
          o.kind = gprg_pkg::KIND_INTER_REF; n = 2'd2;
          if (odd) begin r0 = p - 32'd1; r1 = p - 32'd2 * s; end
          else begin r0 = p - 32'd2 * s; r1 = p - 32'd2 * s + 32'd1; end
          o.expiry = 31'((s + 32'd1) * 32'd2 - 32'd1);
        end else if ((f + 32'd1) % s == 0) begin
          o.kind = gprg_pkg::KIND_INTER_NONREF;
          r0 = p - 32'd2; r1 = p + 32'd2; n = 2'd2; o.expiry = 31'd1;
        end else begin
          o.kind = gprg_pkg::KIND_INTER_REF;
          r0 = p - 32'd2; r1 = (f / s + 32'd1) * s * 32'd2 + 32'(odd); n = 2'd2;
          o.expiry = gprg_pkg::FIELD_MID_EXPIRY;
        end
      end else begin
        if (f == 0) begin
          o.kind = gprg_pkg::KIND_INTRA_REF; o.expiry = gprg_pkg::NEVER_EXPIRES;
        end else if (s == 0) begin
          o.err = 1'b1;
        end else if (f % s == 0) begin
          o.kind = gprg_pkg::KIND_INTER_REF; r0 = '0; n = 2'd1;
          if (f != s) begin r1 = p - 32'd2 * s; n = 2'd2; end
          o.expiry = 31'(s * 32'd2);
        end else begin
          // non-gop l2 fields reference from the picture number itself
          o.kind = gprg_pkg::KIND_INTER_NONREF;
          r0 = (p / s) * s; r1 = (p / s + 32'd1) * s; n = 2'd2;
          o.expiry = 31'd1;
        end
      end
    end
    o.nref = n; o.ref0 = r0; o.ref1 = r1;
    if (o.err) begin
      o = '0;
      o.err = 1'b1;
    end
    return o;
  endfunction

  task automatic send_picture(logic [31:0] p);
    int unsigned gap;
    gap = $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    expected_roles = {expected_roles, predict_role(p)};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(logic [gprg_pkg::CFG_IDX_W-1:0] idx, logic [7:0] v);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gprg_pkg::REG_GOP_LENGTH: gop_len_q = v;
      gprg_pkg::REG_L1_SPACING: l1_sp_q = v;
      gprg_pkg::REG_INTERLACED: field_mode_q = v[0];
      default: ;
    endcase
  endtask

  // drain the pipe before touching registers
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_roles.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic set_gop(logic [7:0] g, logic [7:0] s, logic il);
    wait_idle();
    write_reg(gprg_pkg::REG_GOP_LENGTH, g);
    write_reg(gprg_pkg::REG_L1_SPACING, s);
    write_reg(gprg_pkg::REG_INTERLACED, {7'd0, il});
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random wait after each word, compare with the oldest expectation
  always @(posedge clk_i) begin
    role_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[99:0];
      if (expected_roles.size() == 0) begin
        $display("%0t unexpected word %h", $time, got);
        errors++;
      end else begin
        want = expected_roles.pop_front();
        if (got.kind !== want.kind || got.expiry !== want.expiry ||
            got.nref !== want.nref || got.ref0 !== want.ref0 ||
            got.ref1 !== want.ref1 || got.err !== want.err) begin
          $display("%0t mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
      rx_wait = $urandom_range(0, 13);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    m_axis_tready <= (rx_wait == 0);
  end

  task automatic test_reset_defaults();
    // no gop, spacing 1, progressive straight out of reset
    send_picture(32'd0); send_picture(32'd1); send_picture(32'd2);
    send_picture(32'hFFFF_FFFF);
  endtask

  task automatic test_directed();
    set_gop(8'd12, 8'd3, 1'b0);
    for (int i = 0; i < 8; i++) send_picture(i);
    send_picture(32'hFFFF_FFFF); send_picture(32'h8000_0000);
    set_gop(8'd1, 8'd0, 1'b0);
    send_picture(32'd0); send_picture(32'd5);
    set_gop(8'd4, 8'd0, 1'b1);         // zero spacing gives the error word except at gop starts
    send_picture(32'd0); send_picture(32'd1); send_picture(32'd3);
    set_gop(8'd0, 8'd0, 1'b0);
    send_picture(32'd0); send_picture(32'd7);
    set_gop(8'd255, 8'd255, 1'b1);
    send_picture(32'd0); send_picture(32'd1); send_picture(32'd510);
    send_picture(32'd511); send_picture(32'hFFFF_FFFE);
  endtask

  task automatic test_random();
    logic [31:0] p;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: set_gop(8'd0, 8'd255, 1'b1);
        1: set_gop(8'd255, 8'd1, 1'b0);
        default: set_gop(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(0, 24)),
                         ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 8)),
                         1'($urandom_range(0, 1)));
      endcase
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 3))
          0: p = $urandom();
          1: p = 32'hFFFF_FFFF - $urandom_range(0, 40);
          default: p = $urandom_range(0, 200);
        endcase
        send_picture(p);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_directed();
    test_random();
    wait_idle();
    if (errors == 0 && expected_roles.size() == 0)
      $display("gop_picture_role_generator test passed");
    else
      $display("gop_picture_role_generator test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("gop_picture_role_generator test failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/gprg_pkg.sv
sv/gprg_cell.sv
sv/gop_picture_role_generator.sv
dv/gop_picture_role_generator_tb.sv
